>>> sv/euler_to_quaternion_assert.svh
// Assertion macros for the euler_to_quaternion block.
// Included by the top level; no other dependencies.
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH
`define E2Q_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define E2Q_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> sv/e2q_pkg.sv
// Package for euler_to_quaternion: widths, CORDIC table, helpers.
// No dependencies.
`default_nettype none
package e2q_pkg;
    localparam int ANGLE_BITS    = 16;
    localparam int FRAC_BITS     = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int OUT_BITS      = FRAC_BITS + 2;
    localparam int QD            = 4;
    localparam int QA            = 2;
    localparam int CW            = 32;   // cordic x/y width, Q30
    localparam int ZW            = 33;   // cordic z width
    localparam int PIPE          = CORDIC_STAGES + 4;
    localparam logic signed [CW-1:0] GAIN_Q30 = 32'sd652032874;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] quat_x;
        logic signed [OUT_BITS-1:0] quat_y;
        logic signed [OUT_BITS-1:0] quat_z;
        logic signed [OUT_BITS-1:0] quat_w;
    } t_out;

    function automatic logic [ZW-1:0] atan_turn(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
            3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
            6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
            9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
            12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
            15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
            18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
            21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
            24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
            27: t = 32'd5;         28: t = 32'd3;         29: t = 32'd1;
            30: t = 32'd1;
            default: t = 32'd0;
        endcase
        return {1'b0, t};
    endfunction

    function automatic logic signed [ZW-1:0] half_angle(input logic signed [ANGLE_BITS-1:0] a);
        logic signed [ZW-1:0] w;
        w = ZW'(a) <<< (32 - ANGLE_BITS);
        return w >>> 1;
    endfunction

    function automatic logic signed [OUT_BITS-1:0] to_output(input logic signed [64:0] v);
        logic signed [64:0] r;
        logic signed [64:0] one;
        r   = (v + (65'sd1 <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
        one = 65'sd1 <<< FRAC_BITS;
        if (r > one) r = one;
        if (r < -one) r = -one;
        return r[OUT_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

>>> sv/e2q_stream_if.sv
// Valid/ready channel carrying a payload of type T.
// No dependencies; the payload type is given by the parameter T.
`default_nettype none
interface e2q_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/e2q_cordic.sv
// Pipelined rotation-mode CORDIC, three angles in parallel, one item a cycle while i_en is high.
// Depends on e2q_pkg.
`default_nettype none
module e2q_cordic (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic signed [3*e2q_pkg::ZW-1:0]  i_z,
    output logic signed [e2q_pkg::CW-1:0]         o_c [3],
    output logic signed [e2q_pkg::CW-1:0]         o_s [3]
);
    localparam int N = e2q_pkg::CORDIC_STAGES;
    logic signed [e2q_pkg::CW-1:0] r_x [N+1][3];
    logic signed [e2q_pkg::CW-1:0] r_y [N+1][3];
    logic signed [e2q_pkg::ZW-1:0] r_z [N+1][3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_x[0][k] <= e2q_pkg::GAIN_Q30;
                r_y[0][k] <= '0;
                r_z[0][k] <= i_z[k*e2q_pkg::ZW +: e2q_pkg::ZW];
            end
            for (int i = 0; i < N; i++) begin
                for (int k = 0; k < 3; k++) begin
                    if (!r_z[i][k][e2q_pkg::ZW-1]) begin
                        r_x[i+1][k] <= r_x[i][k] - (r_y[i][k] >>> i);
                        r_y[i+1][k] <= r_y[i][k] + (r_x[i][k] >>> i);
                        r_z[i+1][k] <= r_z[i][k] - e2q_pkg::atan_turn(i);
                    end else begin
                        r_x[i+1][k] <= r_x[i][k] + (r_y[i][k] >>> i);
                        r_y[i+1][k] <= r_y[i][k] - (r_x[i][k] >>> i);
                        r_z[i+1][k] <= r_z[i][k] + e2q_pkg::atan_turn(i);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_c[k] = r_x[N][k];
            o_s[k] = r_y[N][k];
        end
    end
endmodule
`default_nettype wire

>>> sv/e2q_front.sv
// Front: halves angles, runs CORDIC and products, pipeline valid tracking.
// Depends on e2q_pkg, e2q_cordic.
`default_nettype none
module e2q_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire e2q_pkg::t_in             i_data,
    output logic                          o_valid,
    output e2q_pkg::t_out                 o_data
);
    localparam int P = e2q_pkg::PIPE;
    logic [P-1:0] r_vld;
    logic signed [e2q_pkg::CW-1:0] w_c [3];
    logic signed [e2q_pkg::CW-1:0] w_s [3];
    logic signed [e2q_pkg::CW-1:0] r_cc, r_ss, r_sc, r_cs, r_c3, r_s3;
    logic signed [63:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7;
    e2q_pkg::t_out r_out;

    e2q_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_z   ({e2q_pkg::half_angle(i_data.yaw_angle),
                 e2q_pkg::half_angle(i_data.pitch_angle),
                 e2q_pkg::half_angle(i_data.roll_angle)}),
        .o_c   (w_c),
        .o_s   (w_s)
    );

    function automatic logic signed [e2q_pkg::CW-1:0] mq30(
        input logic signed [e2q_pkg::CW-1:0] a, input logic signed [e2q_pkg::CW-1:0] b);
        logic signed [63:0] p;
        p = (64'(a) * 64'(b) + (64'sd1 <<< 29)) >>> 30;
        return p[e2q_pkg::CW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[P-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc <= mq30(w_c[0], w_c[1]);
            r_ss <= mq30(w_s[0], w_s[1]);
            r_sc <= mq30(w_s[0], w_c[1]);
            r_cs <= mq30(w_c[0], w_s[1]);
            r_c3 <= w_c[2];
            r_s3 <= w_s[2];
            r_p0 <= 64'(r_sc) * 64'(r_c3);
            r_p1 <= 64'(r_cs) * 64'(r_s3);
            r_p2 <= 64'(r_cs) * 64'(r_c3);
            r_p3 <= 64'(r_sc) * 64'(r_s3);
            r_p4 <= 64'(r_cc) * 64'(r_s3);
            r_p5 <= 64'(r_ss) * 64'(r_c3);
            r_p6 <= 64'(r_cc) * 64'(r_c3);
            r_p7 <= 64'(r_ss) * 64'(r_s3);
            r_out.quat_x <= e2q_pkg::to_output(65'(r_p0) + 65'(r_p1));
            r_out.quat_y <= e2q_pkg::to_output(65'(r_p2) - 65'(r_p3));
            r_out.quat_z <= e2q_pkg::to_output(65'(r_p4) + 65'(r_p5));
            r_out.quat_w <= e2q_pkg::to_output(65'(r_p6) - 65'(r_p7));
        end
    end

    assign o_valid = r_vld[P-1];
    assign o_data  = r_out;
endmodule
`default_nettype wire

>>> sv/e2q_queue.sv
// Result queue between the pipeline and the output channel.
// Depends on e2q_pkg.
`default_nettype none
module e2q_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire e2q_pkg::t_out i_data,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic [e2q_pkg::QA:0] o_count,
    output e2q_pkg::t_out      o_data
);
    e2q_pkg::t_out r_mem [e2q_pkg::QD];
    logic [e2q_pkg::QA-1:0] r_wp, r_rp;
    logic [e2q_pkg::QA:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (e2q_pkg::QA+1)'(i_push) - (e2q_pkg::QA+1)'(i_pop);
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
endmodule
`default_nettype wire

>>> sv/euler_to_quaternion.sv
// Top level: Euler XYZ angles to Q1.14 quaternion.
// Depends on e2q_pkg, e2q_stream_if, e2q_front, e2q_queue, assert macros.
//  channel  | dir | payload
//  i_in     | in  | roll_angle, pitch_angle, yaw_angle
//  o_out    | out | quat_x, quat_y, quat_z, quat_w
// One item per cycle unless the queue is full and its head not taken.
// The pipeline halts when the output queue is stalled and full; the queue
// depth covers the last result leaving the pipeline.
// Reset clears pipeline valids and queue pointers and count only.
`default_nettype none
`include "euler_to_quaternion_assert.svh"
module euler_to_quaternion (
    input wire logic i_clk,
    input wire logic i_rst_n,
    e2q_stream_if.sink   i_in,
    e2q_stream_if.source o_out
);
    logic w_en, w_fv, w_qv;
    logic [e2q_pkg::QA:0] w_cnt;
    e2q_pkg::t_out w_fd, w_qd;

    // stall pipeline only if queue full and its head not taken
    assign w_en = (w_cnt != (e2q_pkg::QA+1)'(e2q_pkg::QD)) || o_out.ready;
    assign i_in.ready = w_en;

    e2q_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(i_in.valid), .i_data(i_in.data),
        .o_valid(w_fv), .o_data(w_fd)
    );

    e2q_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_fv && w_en), .i_data(w_fd),
        .i_pop(w_qv && o_out.ready),
        .o_valid(w_qv), .o_count(w_cnt), .o_data(w_qd)
    );

    assign o_out.valid = w_qv;
    assign o_out.data  = w_qd;

    `E2Q_ASSERT_IMPL(a_no_overflow, w_fv && w_en, (w_cnt != (e2q_pkg::QA+1)'(e2q_pkg::QD)) || o_out.ready)
    `E2Q_ASSERT_NEXT(a_cnt_bound, 1'b1, w_cnt <= (e2q_pkg::QA+1)'(e2q_pkg::QD))
    `E2Q_ASSERT_IMPL(a_valid_cnt, o_out.valid, w_cnt != '0)
endmodule
`default_nettype wire
